// ===== sv/mpfd_pkg.sv =====
// Shared types and constants of the monochrome page framebuffer drawing engine.
`default_nettype none

package mpfd_pkg;

   localparam int DEFAULT_PANEL_WIDTH  = 128;
   localparam int DEFAULT_PANEL_HEIGHT = 64;
   localparam int PAGE_ROWS            = 8;
   // Row index inside a page.
   localparam int ROW_BITS             = 3;
   // Wide enough for any coordinate on panels of up to 256 by 256 pixels.
   localparam int COORD_W              = 8;
   // Signed span arithmetic on 10-bit corners and sizes without overflow.
   localparam int SPAN_W               = 13;
   localparam int QUEUE_DEPTH          = 2;

   typedef enum logic [2:0] {
      OP_PIXEL   = 3'd0,
      OP_FILL    = 3'd1,
      OP_OUTLINE = 3'd2,
      OP_CLEAR   = 3'd3,
      OP_READ    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_FILL  = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   // One unit of work for the back end: a clipped rectangle, a read, a clear or a no-op.
   typedef struct packed {
      kind_type           kind;
      logic               empty;
      logic               color;
      logic               last;
      logic [COORD_W-1:0] xs;
      logic [COORD_W-1:0] xe;
      logic [COORD_W-1:0] ys;
      logic [COORD_W-1:0] ye;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== sv/mpfd_front.sv =====
// Front end: accepts commands, clips them to the panel and splits outlines into four spans.
`default_nettype none

module mpfd_front
   import mpfd_pkg::*;
#(
   parameter int PANEL_WIDTH  = DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = DEFAULT_PANEL_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_op,
   input  logic signed [9:0]       req_x,
   input  logic signed [9:0]       req_y,
   input  logic signed [9:0]       req_w,
   input  logic signed [9:0]       req_h,
   input  logic                    req_color,
   input  logic                    init_busy,
   input  queue_status_type        q_status,
   output logic                    q_push,
   output entry_type               q_entry
);

   localparam logic [1:0] SEG_TOP    = 2'd0;
   localparam logic [1:0] SEG_BOTTOM = 2'd1;
   localparam logic [1:0] SEG_LEFT   = 2'd2;
   localparam logic [1:0] SEG_RIGHT  = 2'd3;

   localparam logic signed [SPAN_W-1:0] ONE  = SPAN_W'(1);
   localparam logic signed [SPAN_W-1:0] ZERO = SPAN_W'(0);
   localparam logic signed [SPAN_W-1:0] PW   = SPAN_W'(PANEL_WIDTH);
   localparam logic signed [SPAN_W-1:0] PH   = SPAN_W'(PANEL_HEIGHT);

   logic [1:0] seg_ff, seg_in;

   logic signed [SPAN_W-1:0] x, y, w, h;
   logic signed [SPAN_W-1:0] sx, sy, sw, sh;
   logic signed [SPAN_W-1:0] x0, y0, x1, y1, xl, yl;
   logic                     nx, ny, last;

   assign x = SPAN_W'(req_x);
   assign y = SPAN_W'(req_y);
   assign w = SPAN_W'(req_w);
   assign h = SPAN_W'(req_h);

   always_comb begin
      sx = x;
      sy = y;
      sw = ONE;
      sh = ONE;
      case (req_op)
         OP_FILL: begin
            sw = w;
            sh = h;
         end
         OP_OUTLINE: begin
            // The outline is the union of two rows and two columns, each a one-pixel fill.
            case (seg_ff)
               SEG_TOP: begin
                  sw = w;
               end
               SEG_BOTTOM: begin
                  sy = y + h - ONE;
                  sw = w;
               end
               SEG_LEFT: begin
                  sh = h;
               end
               default: begin
                  sx = x + w - ONE;
                  sh = h;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      x0 = (sx < ZERO) ? ZERO : sx;
      y0 = (sy < ZERO) ? ZERO : sy;
      x1 = sx + sw;
      y1 = sy + sh;
      if (x1 > PW) begin
         x1 = PW;
      end
      if (y1 > PH) begin
         y1 = PH;
      end
      xl = x1 - ONE;
      yl = y1 - ONE;
      nx = x1 > x0;
      ny = y1 > y0;
   end

   assign last = (req_op != OP_OUTLINE) || (seg_ff == SEG_RIGHT);

   always_comb begin
      q_entry.empty = !(nx && ny);
      q_entry.color = req_color;
      q_entry.last  = last;
      q_entry.xs    = x0[COORD_W-1:0];
      q_entry.xe    = xl[COORD_W-1:0];
      q_entry.ys    = y0[COORD_W-1:0];
      q_entry.ye    = yl[COORD_W-1:0];
      case (req_op)
         OP_PIXEL, OP_FILL, OP_OUTLINE: q_entry.kind = KIND_FILL;
         OP_CLEAR:                      q_entry.kind = KIND_CLEAR;
         OP_READ:                       q_entry.kind = KIND_READ;
         default:                       q_entry.kind = KIND_NOP;
      endcase
   end

   assign q_push    = req_valid && !init_busy && !q_status.full;
   assign req_stall = init_busy || q_status.full || !last;

   always_comb begin
      seg_in = seg_ff;
      if (q_push) begin
         seg_in = last ? SEG_TOP : seg_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= SEG_TOP;
      end else begin
         seg_ff <= seg_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mpfd_queue.sv =====
// Short command queue between the front end and the drawing back end.
`default_nettype none

module mpfd_queue
   import mpfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mpfd_back.sv =====
// Back end: frame store, byte-wise read-modify-write walker, clearing sweep and result register.
`default_nettype none

module mpfd_back
   import mpfd_pkg::*;
#(
   parameter int PANEL_WIDTH  = DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = DEFAULT_PANEL_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  entry_type        q_head,
   input  queue_status_type q_status,
   output logic             q_pop,
   output logic             init_busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_read_byte,
   output logic             rsp_read_valid
);

   localparam int PAGE_COUNT  = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
   localparam int COL_W       = $clog2(PANEL_WIDTH);
   localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
   localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(PANEL_WIDTH);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_RD    = 7'b0000100,
      S_WR    = 7'b0001000,
      S_RDR   = 7'b0010000,
      S_CLEAR = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   entry_type         cmd_ff, cmd_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_hit_ff, rsp_hit_in;

   logic [7:0]        frame_store [STORE_BYTES];
   logic [7:0]        rd_data_ff;

   logic              mem_rd, mem_we;
   logic [ADDR_W-1:0] addr, mem_waddr;
   logic [7:0]        mem_wdata, mask;
   logic [PAGE_W-1:0] ys_page, ye_page, head_page;
   logic [ROW_BITS-1:0] lo_row, hi_row;
   logic              out_free, last_col, last_page, read_hit;

   assign ys_page   = PAGE_W'(cmd_ff.ys >> ROW_BITS);
   assign ye_page   = PAGE_W'(cmd_ff.ye >> ROW_BITS);
   assign head_page = PAGE_W'(q_head.ys >> ROW_BITS);
   assign addr      = ADDR_W'(col_ff) + ADDR_W'(page_ff) * ROW_PITCH;
   assign last_col  = (col_ff == cmd_ff.xs[COL_W-1:0] + (cmd_ff.xe[COL_W-1:0]
                       - cmd_ff.xs[COL_W-1:0]));
   assign last_page = (page_ff == ye_page);
   assign read_hit  = (cmd_ff.kind == KIND_READ) && !cmd_ff.empty;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Rows of the current page that lie inside the span.
   always_comb begin
      lo_row = (page_ff == ys_page) ? cmd_ff.ys[ROW_BITS-1:0] : '0;
      hi_row = (page_ff == ye_page) ? cmd_ff.ye[ROW_BITS-1:0] : '1;
      mask   = (8'hFF << lo_row) & (8'hFF >> (3'd7 - hi_row));
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      page_in      = page_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_hit_in   = rsp_hit_ff;
      q_pop        = 1'b0;
      mem_rd       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr;
      mem_wdata    = (rd_data_ff & ~mask) | (cmd_ff.color ? mask : 8'h00);
      case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'h00;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (!q_status.empty) begin
               q_pop   = 1'b1;
               cmd_in  = q_head;
               col_in  = q_head.xs[COL_W-1:0];
               page_in = head_page;
               clr_in  = '0;
               case (q_head.kind)
                  KIND_FILL:  state_in = q_head.empty ? S_DONE : S_RD;
                  KIND_READ:  state_in = q_head.empty ? S_DONE : S_RDR;
                  KIND_CLEAR: state_in = S_CLEAR;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_RD: begin
            mem_rd   = 1'b1;
            state_in = S_WR;
         end
         S_WR: begin
            mem_we   = 1'b1;
            state_in = S_RD;
            if (last_col) begin
               col_in = cmd_ff.xs[COL_W-1:0];
               if (last_page) begin
                  state_in = S_DONE;
               end else begin
                  page_in = page_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         S_RDR: begin
            mem_rd   = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // Only the last piece of a command produces the result transfer.
            if (!cmd_ff.last) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = read_hit ? rd_data_ff : 8'h00;
               rsp_hit_in   = read_hit;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      col_ff      <= col_in;
      page_ff     <= page_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store[mem_waddr] <= mem_wdata;
      end
      if (mem_rd) begin
         rd_data_ff <= frame_store[addr];
      end
   end

   assign init_busy      = (state_ff == S_INIT);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_byte  = rsp_byte_ff;
   assign rsp_read_valid = rsp_hit_ff;

endmodule

`default_nettype wire

// ===== sv/mono_page_framebuffer_draw.sv =====
// A fill span reads and then writes back each store byte that it touches (columns times pages);
// an outline runs as four such spans, and a clear-all writes zero to every store byte. A read
// fetches one byte, and a command that touches no store byte goes straight to the result.
// After reset the store is swept to zero, one byte at a time over all
// PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes (1024 by default), and req_stall stays high throughout.
`default_nettype none

module mono_page_framebuffer_draw
   import mpfd_pkg::*;
#(
   parameter int PANEL_WIDTH  = DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = DEFAULT_PANEL_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_op,
   input  logic signed [9:0] req_x,
   input  logic signed [9:0] req_y,
   input  logic signed [9:0] req_w,
   input  logic signed [9:0] req_h,
   input  logic              req_color,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_read_valid
);

   queue_status_type q_status;
   entry_type        q_entry, q_head;
   logic             q_push, q_pop, init_busy;

   mpfd_front #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op   (req_op),
      .req_x    (req_x),
      .req_y    (req_y),
      .req_w    (req_w),
      .req_h    (req_h),
      .req_color(req_color),
      .init_busy(init_busy),
      .q_status (q_status),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   mpfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   mpfd_back #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_head        (q_head),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .init_busy     (init_busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_read_byte (rsp_read_byte),
      .rsp_read_valid(rsp_read_valid)
   );

`ifndef SYNTHESIS
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("command queue written while full");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("command queue read while empty");

   a_stall_during_sweep : assert property (@(posedge clock) disable iff (reset)
      init_busy |-> (req_stall && !q_push))
      else $error("command taken during the reset clearing sweep");
`endif

endmodule

`default_nettype wire
